[rtl/wsad_pkg.sv]
// ----------------------------------------------------------------------------
// wsad_pkg
// Shared types and constants for the weighted SAD template scorer.
// ----------------------------------------------------------------------------
package wsad_pkg;

    localparam int COORD_W    = 16;
    localparam int TSIZE_W    = 9;
    localparam int OFFSET_W   = 8;
    localparam int RGB_W      = 24;
    localparam int CHAN_W     = 8;
    localparam int WEIGHT_W   = 17;
    localparam int FRAME_W    = 13;
    localparam int SCORE_W    = 26;
    localparam int DIFF_W     = 10;
    localparam int PROD_W     = DIFF_W + WEIGHT_W;
    localparam int CFG_IDX_W  = 1;

    // Template size is clamped to this before its center is taken
    localparam int MAX_TEMPLATE_DIM = 256;
    localparam int WEIGHT_FRAC_BITS = 16;

    localparam logic [DIFF_W-1:0]  OOB_PENALTY = DIFF_W'(255);
    localparam logic [SCORE_W-1:0] SCORE_MAX   = {SCORE_W{1'b1}};

    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = FRAME_W'(640);
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = FRAME_W'(480);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] place_x;
        logic signed [COORD_W-1:0] place_y;
        logic [TSIZE_W-1:0]        tmpl_width;
        logic [TSIZE_W-1:0]        tmpl_height;
        logic [OFFSET_W-1:0]       offset_x;
        logic [OFFSET_W-1:0]       offset_y;
        logic [RGB_W-1:0]          tmpl_rgb;
        logic [RGB_W-1:0]          frame_rgb;
        logic [WEIGHT_W-1:0]       weight;
        logic                      last;
    } pix_t;

    // Control of the addend stage
    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctl_t;

endpackage

[rtl/weighted_sad_template_score.sv]
// ----------------------------------------------------------------------------
// weighted_sad_template_score
// Weighted sum of absolute RGB differences for one template placement.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | input     | in_valid / in_stall  | place_x .. last
//   out     | output    | out_valid / out_stall| score
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One pixel per cycle while in_stall is low: input register, addend register (bounds, SAD and the
// weight multiply), then the accumulator feeding the result register.
// A last pixel passes through the input and addend registers before its score is registered.
// rst_n clears the pipeline valids and the accumulator, and sets the frame size
// registers (640 x 480). cfg_ready is always high.
// A stalled score blocks only a last pixel in the addend stage and the stages behind it; non-last pixels keep flowing.
// ----------------------------------------------------------------------------
module weighted_sad_template_score #(
    parameter int WEIGHT_FRAC_BITS = wsad_pkg::WEIGHT_FRAC_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [wsad_pkg::COORD_W-1:0] place_x,
    input  logic signed [wsad_pkg::COORD_W-1:0] place_y,
    input  logic [wsad_pkg::TSIZE_W-1:0]   tmpl_width,
    input  logic [wsad_pkg::TSIZE_W-1:0]   tmpl_height,
    input  logic [wsad_pkg::OFFSET_W-1:0]  offset_x,
    input  logic [wsad_pkg::OFFSET_W-1:0]  offset_y,
    input  logic [wsad_pkg::RGB_W-1:0]     tmpl_rgb,
    input  logic [wsad_pkg::RGB_W-1:0]     frame_rgb,
    input  logic [wsad_pkg::WEIGHT_W-1:0]  weight,
    input  logic                           last,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [wsad_pkg::SCORE_W-1:0]   score,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wsad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wsad_pkg::FRAME_W-1:0]   cfg_data
);

    localparam int ADD_W = wsad_pkg::PROD_W - WEIGHT_FRAC_BITS;

    logic [wsad_pkg::FRAME_W-1:0] frame_width_reg;
    logic [wsad_pkg::FRAME_W-1:0] frame_width_next;
    logic [wsad_pkg::FRAME_W-1:0] frame_height_reg;
    logic [wsad_pkg::FRAME_W-1:0] frame_height_next;

    logic           s1_valid_reg;
    logic           s1_valid_next;
    wsad_pkg::pix_t s1_pix_reg;
    wsad_pkg::pix_t in_pix;

    wsad_pkg::stage_ctl_t s2_ctl;
    logic [ADD_W-1:0]     s2_addend;
    logic                 s2_free;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                wsad_pkg::REG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                wsad_pkg::REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        in_pix.place_x     = place_x;
        in_pix.place_y     = place_y;
        in_pix.tmpl_width  = tmpl_width;
        in_pix.tmpl_height = tmpl_height;
        in_pix.offset_x    = offset_x;
        in_pix.offset_y    = offset_y;
        in_pix.tmpl_rgb    = tmpl_rgb;
        in_pix.frame_rgb   = frame_rgb;
        in_pix.weight      = weight;
        in_pix.last        = last;

        in_stall      = s1_valid_reg && !s2_free;
        s1_valid_next = in_stall ? s1_valid_reg : in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= wsad_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= wsad_pkg::FRAME_HEIGHT_RST;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            s1_valid_reg     <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_pix_reg <= in_pix;
        end
    end

    wsad_diff #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
        .ADD_W            (ADD_W)
    ) u_diff (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_valid    (s1_valid_reg),
        .pix          (s1_pix_reg),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .stage_free   (s2_free),
        .ctl          (s2_ctl),
        .addend       (s2_addend)
    );

    wsad_accum #(
        .ADD_W (ADD_W)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (s2_ctl),
        .addend     (s2_addend),
        .stage_free (s2_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .score      (score)
    );

endmodule

[rtl/wsad_diff.sv]
// ----------------------------------------------------------------------------
// wsad_diff
// Maps a pixel into the frame, picks the RGB SAD or the out-of-bounds
// penalty, weights it, and registers the truncated addend.
// ----------------------------------------------------------------------------
module wsad_diff #(
    parameter int WEIGHT_FRAC_BITS = wsad_pkg::WEIGHT_FRAC_BITS,
    parameter int ADD_W            = wsad_pkg::PROD_W - WEIGHT_FRAC_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pix_valid,
    input  wsad_pkg::pix_t              pix,
    input  logic [wsad_pkg::FRAME_W-1:0] frame_width,
    input  logic [wsad_pkg::FRAME_W-1:0] frame_height,
    input  logic                        stage_free,
    output wsad_pkg::stage_ctl_t        ctl,
    output logic [ADD_W-1:0]            addend
);

    localparam int FC_W = wsad_pkg::COORD_W + 1;

    wsad_pkg::stage_ctl_t ctl_reg;
    wsad_pkg::stage_ctl_t ctl_next;
    logic [ADD_W-1:0]     addend_reg;
    logic [ADD_W-1:0]     addend_next;

    logic [wsad_pkg::OFFSET_W-1:0] centre_x;
    logic [wsad_pkg::OFFSET_W-1:0] centre_y;
    logic signed [FC_W-1:0]        fx;
    logic signed [FC_W-1:0]        fy;
    logic                          oob;
    logic [wsad_pkg::CHAN_W-1:0]   ad_r;
    logic [wsad_pkg::CHAN_W-1:0]   ad_g;
    logic [wsad_pkg::CHAN_W-1:0]   ad_b;
    logic [wsad_pkg::DIFF_W-1:0]   diff;
    logic [wsad_pkg::PROD_W-1:0]   product;

    function automatic logic [wsad_pkg::CHAN_W-1:0] abs_diff(
        input logic [wsad_pkg::CHAN_W-1:0] a,
        input logic [wsad_pkg::CHAN_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [wsad_pkg::OFFSET_W-1:0] centre_of(
        input logic [wsad_pkg::TSIZE_W-1:0] size
    );
        if (32'(size) > 32'(wsad_pkg::MAX_TEMPLATE_DIM))
        begin
            return wsad_pkg::OFFSET_W'(wsad_pkg::MAX_TEMPLATE_DIM / 2);
        end
        return size[wsad_pkg::TSIZE_W-1:1];
    endfunction

    always_comb
    begin
        centre_x = centre_of(pix.tmpl_width);
        centre_y = centre_of(pix.tmpl_height);
        fx = FC_W'(pix.place_x) + $signed(FC_W'(pix.offset_x))
           - $signed(FC_W'(centre_x));
        fy = FC_W'(pix.place_y) + $signed(FC_W'(pix.offset_y))
           - $signed(FC_W'(centre_y));
        // Non-negative coordinates fit in the low 16 bits
        oob = fx[FC_W-1] || fy[FC_W-1]
           || (fx[FC_W-2:0] >= (FC_W-1)'(frame_width))
           || (fy[FC_W-2:0] >= (FC_W-1)'(frame_height));

        ad_r = abs_diff(pix.frame_rgb[23:16], pix.tmpl_rgb[23:16]);
        ad_g = abs_diff(pix.frame_rgb[15:8],  pix.tmpl_rgb[15:8]);
        ad_b = abs_diff(pix.frame_rgb[7:0],   pix.tmpl_rgb[7:0]);
        diff = oob ? wsad_pkg::OOB_PENALTY
                   : wsad_pkg::DIFF_W'(ad_r) + wsad_pkg::DIFF_W'(ad_g)
                     + wsad_pkg::DIFF_W'(ad_b);

        product     = wsad_pkg::PROD_W'(diff) * wsad_pkg::PROD_W'(pix.weight);
        addend_next = product[wsad_pkg::PROD_W-1:WEIGHT_FRAC_BITS];

        ctl_next.valid = pix_valid;
        ctl_next.last  = pix.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (stage_free)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_free && pix_valid)
        begin
            addend_reg <= addend_next;
        end
    end

    assign ctl    = ctl_reg;
    assign addend = addend_reg;

endmodule

[rtl/wsad_accum.sv]
// ----------------------------------------------------------------------------
// wsad_accum
// Saturating score accumulator and the result register.
// ----------------------------------------------------------------------------
module wsad_accum #(
    parameter int ADD_W = wsad_pkg::PROD_W - wsad_pkg::WEIGHT_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wsad_pkg::stage_ctl_t         ctl,
    input  logic [ADD_W-1:0]             addend,
    output logic                         stage_free,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [wsad_pkg::SCORE_W-1:0] score
);

    localparam int SUM_W = wsad_pkg::SCORE_W + 1;

    logic [wsad_pkg::SCORE_W-1:0] running_reg;
    logic [wsad_pkg::SCORE_W-1:0] running_next;
    logic [wsad_pkg::SCORE_W-1:0] score_reg;
    logic [wsad_pkg::SCORE_W-1:0] score_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    logic                         out_free;
    logic                         stage_go;
    logic [SUM_W-1:0]             sum;
    logic [wsad_pkg::SCORE_W-1:0] sum_sat;

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;
        // A non-last pixel only touches the accumulator, so it never waits
        stage_go   = ctl.valid && (!ctl.last || out_free);
        stage_free = !ctl.valid || stage_go;

        sum     = SUM_W'(running_reg) + SUM_W'(addend);
        sum_sat = sum[SUM_W-1] ? wsad_pkg::SCORE_MAX : sum[wsad_pkg::SCORE_W-1:0];

        running_next   = running_reg;
        score_next     = score_reg;
        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        if (stage_go)
        begin
            if (ctl.last)
            begin
                running_next   = '0;
                score_next     = sum_sat;
                out_valid_next = 1'b1;
            end
            else
            begin
                running_next = sum_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
    end

    assign out_valid = out_valid_reg;
    assign score     = score_reg;

endmodule

[rtl/wsad_checker.sv]
// ----------------------------------------------------------------------------
// wsad_checker
// Port-level checks for the weighted SAD template scorer.
// ----------------------------------------------------------------------------
module wsad_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [wsad_pkg::SCORE_W-1:0]   score,
    input logic                           cfg_ready
);

    // A stalled score stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(score))
        else $error("stalled score changed");

    // Input back-pressure only comes from a blocked score
    a_stall_cause: assert property (@(posedge clk)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid && !in_stall)
        else $error("activity during reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind weighted_sad_template_score wsad_checker u_wsad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .score     (score),
    .cfg_ready (cfg_ready)
);

[tb/wsad_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsad_tb_pkg
// Placement score predictor and result checker for the weighted SAD scorer.
// Accepted pixels update a local copy of the accumulator, register writes the frame size;
// every last pixel queues one expected score.
// ----------------------------------------------------------------------------
package wsad_tb_pkg;

    import wsad_pkg::*;

    class placement_scoreboard;

        logic [FRAME_W-1:0] frame_w;
        logic [FRAME_W-1:0] frame_h;
        logic [SCORE_W-1:0] partial_score;
        logic [SCORE_W-1:0] expected_scores[$];
        int                 errors;

        function new();
            frame_w       = FRAME_WIDTH_RST;
            frame_h       = FRAME_HEIGHT_RST;
            partial_score = '0;
            errors        = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAME_W-1:0] data);
            if (idx == REG_FRAME_WIDTH)
                frame_w = data;
            else
                frame_h = data;
        endfunction

        // Center of one template dimension, clamped to the largest template
        function int half_span(logic [TSIZE_W-1:0] size);
            int s;
            s = int'(size);
            if (s > MAX_TEMPLATE_DIM)
                s = MAX_TEMPLATE_DIM;
            return s / 2;
        endfunction

        function int chan_gap(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
            return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        endfunction

        function void note_pixel(pix_t p);
            int     col;
            int     row;
            int     diff;
            longint total;
            col = int'($signed(p.place_x)) + int'(p.offset_x) - half_span(p.tmpl_width);
            row = int'($signed(p.place_y)) + int'(p.offset_y) - half_span(p.tmpl_height);
            if (p.weight != '0)
            begin
                if (col < 0 || row < 0 || col >= int'(frame_w) || row >= int'(frame_h))
                begin
                    diff = int'(OOB_PENALTY);
                end
                else
                begin
                    diff = 0;
                    for (int c = 0; c < 3; c++)
                        diff += chan_gap(p.tmpl_rgb[c*CHAN_W +: CHAN_W],
                                         p.frame_rgb[c*CHAN_W +: CHAN_W]);
                end
                // product truncated to whole units, then saturating add
                total = longint'(partial_score)
                      + ((longint'(diff) * longint'(p.weight)) >> WEIGHT_FRAC_BITS);
                partial_score = (total > longint'(SCORE_MAX)) ? SCORE_MAX
                                                              : total[SCORE_W-1:0];
            end
            if (p.last)
            begin
                expected_scores.push_back(partial_score);
                partial_score = '0;
            end
        endfunction

        task report_mismatch(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_score(logic [SCORE_W-1:0] got);
            logic [SCORE_W-1:0] want;
            if (expected_scores.size() == 0)
            begin
                report_mismatch($sformatf("score %0d with no placement pending", got));
                return;
            end
            want = expected_scores.pop_front();
            if (got !== want)
                report_mismatch($sformatf("score %0d, expected %0d", got, want));
        endtask

        function int pending();
            return expected_scores.size();
        endfunction

    endclass

endpackage

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for weighted_sad_template_score. Directed pixels hit
// the frame edges, template size clamping, weight extremes, truncation and
// a zero-sized frame; a long placement runs at full difference and weight;
// random placements follow under several frame sizes with random idle and
// stall bursts and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import wsad_pkg::*;
    import wsad_tb_pkg::*;

    localparam int W_ONE         = 65536;
    localparam int W_MAX         = 131071;
    localparam int LONG_PIXELS   = 40;
    localparam int RAND_ITEMS    = 180;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic signed [COORD_W-1:0]  place_x;
    logic signed [COORD_W-1:0]  place_y;
    logic [TSIZE_W-1:0]         tmpl_width;
    logic [TSIZE_W-1:0]         tmpl_height;
    logic [OFFSET_W-1:0]        offset_x;
    logic [OFFSET_W-1:0]        offset_y;
    logic [RGB_W-1:0]           tmpl_rgb;
    logic [RGB_W-1:0]           frame_rgb;
    logic [WEIGHT_W-1:0]        weight;
    logic                       last;
    logic                       out_valid;
    logic                       out_stall;
    logic [SCORE_W-1:0]         score;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [FRAME_W-1:0]         cfg_data;

    bit                         in_idle_on;
    bit                         out_idle_on;
    bit                         hold_req;
    placement_scoreboard        sb;

    weighted_sad_template_score DUT (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_score(score);
    end

    // Output side: random stall bursts, plus one long hold-off on request
    initial
    begin
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (out_idle_on && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic pix_t pixel_of(int px, int py, int tw, int th, int ox, int oy,
                                      logic [RGB_W-1:0] trgb, logic [RGB_W-1:0] frgb,
                                      int w, bit lst);
        pix_t p;
        p.place_x     = px[COORD_W-1:0];
        p.place_y     = py[COORD_W-1:0];
        p.tmpl_width  = tw[TSIZE_W-1:0];
        p.tmpl_height = th[TSIZE_W-1:0];
        p.offset_x    = ox[OFFSET_W-1:0];
        p.offset_y    = oy[OFFSET_W-1:0];
        p.tmpl_rgb    = trgb;
        p.frame_rgb   = frgb;
        p.weight      = w[WEIGHT_W-1:0];
        p.last        = lst;
        return p;
    endfunction

    // Called right after a rising edge; returns at the edge of the transfer
    task automatic send_pixel(input pix_t p);
        int gap;
        if (in_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        place_x     <= p.place_x;
        place_y     <= p.place_y;
        tmpl_width  <= p.tmpl_width;
        tmpl_height <= p.tmpl_height;
        offset_x    <= p.offset_x;
        offset_y    <= p.offset_y;
        tmpl_rgb    <= p.tmpl_rgb;
        frame_rgb   <= p.frame_rgb;
        weight      <= p.weight;
        last        <= p.last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_pixel(p);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        // non-last pixels may still be in the pipe
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(input int w, input int h);
        cfg_valid <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= FRAME_W'(w);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(REG_FRAME_WIDTH, FRAME_W'(w));
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= FRAME_W'(h);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(REG_FRAME_HEIGHT, FRAME_W'(h));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int n_items);
        pix_t p;
        int   left;
        int   len;
        int   tw;
        int   th;
        int   px;
        int   py;
        left = n_items;
        while (left > 0)
        begin
            len = $urandom_range(1, 8);
            if (len > left)
                len = left;
            tw = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(0, 511);
            th = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(0, 511);
            if ($urandom_range(0, 3) != 0)
            begin
                // around the frame, so both sides of each edge get hit
                px = int'($urandom_range(0, sb.frame_w + 2 * tw + 2)) - tw - 1;
                py = int'($urandom_range(0, sb.frame_h + 2 * th + 2)) - th - 1;
            end
            else
            begin
                px = $urandom;
                py = $urandom;
            end
            p.place_x     = px[COORD_W-1:0];
            p.place_y     = py[COORD_W-1:0];
            p.tmpl_width  = tw[TSIZE_W-1:0];
            p.tmpl_height = th[TSIZE_W-1:0];
            for (int k = 0; k < len; k++)
            begin
                p.offset_x = OFFSET_W'((tw > 0 && $urandom_range(0, 6) != 0)
                           ? $urandom_range(0, (tw > 256) ? 255 : tw - 1)
                           : $urandom_range(0, 255));
                p.offset_y = OFFSET_W'((th > 0 && $urandom_range(0, 6) != 0)
                           ? $urandom_range(0, (th > 256) ? 255 : th - 1)
                           : $urandom_range(0, 255));
                case ($urandom_range(0, 19)) inside
                    [0:2]:   p.weight = '0;
                    [3:7]:   p.weight = WEIGHT_W'($urandom_range(0, W_MAX));
                    default: p.weight = WEIGHT_W'($urandom_range(0, W_ONE));
                endcase
                p.tmpl_rgb  = RGB_W'($urandom);
                p.frame_rgb = RGB_W'($urandom);
                p.last      = (k == len - 1);
                send_pixel(p);
            end
            left -= len;
        end
    endtask

    initial
    begin
        sb = new();
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        place_x     <= '0;
        place_y     <= '0;
        tmpl_width  <= '0;
        tmpl_height <= '0;
        offset_x    <= '0;
        offset_y    <= '0;
        tmpl_rgb    <= '0;
        frame_rgb   <= '0;
        weight      <= '0;
        last        <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_FRAME_WIDTH;
        cfg_data    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;

        // reset frame size 640 x 480
        send_pixel(pixel_of(0, 0, 1, 1, 0, 0, 24'h000000, 24'hFFFFFF, W_ONE, 1));
        // zero weight adds nothing, even off the frame
        send_pixel(pixel_of(-32768, 32767, 511, 511, 255, 255, 24'hFFFFFF, 24'h000000, 0, 1));
        send_pixel(pixel_of(-32768, 32767, 0, 0, 0, 0, 24'h000000, 24'h000000, W_MAX, 1));
        send_pixel(pixel_of(32767, -32768, 0, 0, 0, 0, 24'h000000, 24'h000000, W_MAX, 1));
        // both sides of every frame edge
        send_pixel(pixel_of(639, 0, 1, 1, 0, 0, 24'h123456, 24'h654321, W_ONE, 0));
        send_pixel(pixel_of(640, 0, 1, 1, 0, 0, 24'h123456, 24'h654321, W_ONE, 0));
        send_pixel(pixel_of(0, 479, 1, 1, 0, 0, 24'h123456, 24'h654321, W_ONE, 0));
        send_pixel(pixel_of(0, 480, 1, 1, 0, 0, 24'h123456, 24'h654321, W_ONE, 0));
        send_pixel(pixel_of(-1, 0, 1, 1, 0, 0, 24'h123456, 24'h654321, W_ONE, 0));
        send_pixel(pixel_of(0, -1, 1, 1, 0, 0, 24'h123456, 24'h654321, W_ONE, 1));
        // zero template size, then sizes past the clamp
        send_pixel(pixel_of(0, 0, 0, 0, 0, 0, 24'h80FF01, 24'h7F00FE, W_ONE, 0));
        send_pixel(pixel_of(128, 128, 511, 511, 0, 0, 24'hAA55AA, 24'h55AA55, W_ONE, 0));
        send_pixel(pixel_of(127, 127, 257, 256, 0, 0, 24'hAA55AA, 24'h55AA55, W_ONE, 0));
        // offset past the template edge
        send_pixel(pixel_of(100, 100, 4, 4, 255, 255, 24'h102030, 24'h302010, W_ONE, 1));
        // products that lose their fraction
        send_pixel(pixel_of(5, 5, 1, 1, 0, 0, 24'h000001, 24'h000000, 1, 0));
        send_pixel(pixel_of(5, 5, 1, 1, 0, 0, 24'h010101, 24'h000000, 32767, 0));
        send_pixel(pixel_of(5, 5, 1, 1, 0, 0, 24'h030201, 24'h000000, W_ONE + 1, 1));

        // empty frame: every pixel is off the frame
        drain();
        set_frame(0, 0);
        send_pixel(pixel_of(0, 0, 1, 1, 0, 0, 24'h000000, 24'hFFFFFF, W_ONE, 1));

        drain();
        set_frame(8191, 8191);
        send_pixel(pixel_of(8190, 8190, 1, 1, 0, 0, 24'h00FF00, 24'hFF00FF, W_ONE, 0));
        send_pixel(pixel_of(8191, 0, 1, 1, 0, 0, 24'h00FF00, 24'hFF00FF, W_ONE, 0));
        send_pixel(pixel_of(0, 8191, 1, 1, 0, 0, 24'h00FF00, 24'hFF00FF, W_ONE, 1));

        drain();
        set_frame(1, 1);
        send_pixel(pixel_of(0, 0, 1, 1, 0, 0, 24'h0F0F0F, 24'hF0F0F0, W_ONE, 0));
        send_pixel(pixel_of(1, 0, 1, 1, 0, 0, 24'h0F0F0F, 24'hF0F0F0, W_ONE, 0));
        send_pixel(pixel_of(0, 1, 1, 1, 0, 0, 24'h0F0F0F, 24'hF0F0F0, W_ONE, 1));

        // one long back-to-back placement at full difference and weight
        drain();
        set_frame(4096, 4096);
        in_idle_on = 1'b0;
        for (int k = 0; k < LONG_PIXELS; k++)
            send_pixel(pixel_of(4095, 4095, 1, 1, 0, 0, 24'h000000, 24'hFFFFFF, W_MAX,
                                k == LONG_PIXELS - 1));
        send_pixel(pixel_of(0, 0, 1, 1, 0, 0, 24'h000000, 24'h010203, W_ONE, 1));
        in_idle_on = 1'b1;

        // output held off long enough to back the pipe up into the input
        drain();
        set_frame($urandom_range(1, 64), $urandom_range(1, 64));
        hold_req = 1'b1;
        random_phase(RAND_ITEMS);

        drain();
        set_frame(4096, 4096);
        random_phase(RAND_ITEMS);

        drain();
        set_frame($urandom_range(0, 8191), $urandom_range(0, 8191));
        random_phase(RAND_ITEMS);

        drain();
        set_frame($urandom_range(1, 8), $urandom_range(1, 8));
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        random_phase(RAND_ITEMS);

        drain();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/wsad_pkg.sv
rtl/wsad_diff.sv
rtl/wsad_accum.sv
rtl/weighted_sad_template_score.sv
rtl/wsad_checker.sv
tb/wsad_tb_pkg.sv
tb/testbench.sv
